FILE: hdl/md3vn_pkg.sv
// ----------------------------------------------------------------------------
// md3vn_pkg
// Shared types, register codes and trig table for the vertex/normal transform.
// ----------------------------------------------------------------------------
package md3vn_pkg;

  localparam int TRIG_FRAC_BITS = 15;
  localparam int TRIG_SH        = 15 - TRIG_FRAC_BITS;
  localparam int TRIG_RND       = (TRIG_SH > 0) ? (2 ** TRIG_SH) / 2 : 0;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_YAW_COS  = 3'd0,
    REG_YAW_SIN  = 3'd1,
    REG_ORIGIN_X = 3'd2,
    REG_ORIGIN_Y = 3'd3,
    REG_ORIGIN_Z = 3'd4
  } cfg_reg_t;

  typedef logic signed [16:0] trig_t;

  // Quarter-wave sine, Q1.15, k * pi/128 for k = 0..64
  localparam logic [15:0] QSINE [65] = '{
    16'd0,     16'd804,   16'd1608,  16'd2411,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
    16'd6393,  16'd7180,  16'd7962,  16'd8740,  16'd9512,  16'd10279, 16'd11039, 16'd11793,
    16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151, 16'd16846, 16'd17531,
    16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788, 16'd21403, 16'd22006, 16'd22595,
    16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25833, 16'd26320, 16'd26791,
    16'd27246, 16'd27684, 16'd28106, 16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957,
    16'd30274, 16'd30572, 16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972,
    16'd32138, 16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
    16'd32768
  };

  function automatic trig_t rom_sine(input logic [7:0] code);
    logic [5:0]  r;
    logic [1:0]  q;
    logic [6:0]  idx;
    logic [16:0] m;
    r   = code[5:0];
    q   = code[7:6];
    idx = q[0] ? (7'd64 - {1'b0, r}) : {1'b0, r};
    m   = {1'b0, QSINE[idx]};
    // trim the magnitude to the configured fraction, nearest with ties up
    m   = ((m + 17'(TRIG_RND)) >> TRIG_SH) << TRIG_SH;
    return q[1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic trig_t rom_cosine(input logic [7:0] code);
    return rom_sine(code + 8'd64);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'sd32767;
    end else if (v < -19'sd32768) begin
      return -16'sd32768;
    end
    return v[15:0];
  endfunction

endpackage

FILE: hdl/md3_vertex_normal_transform_top.sv
// ----------------------------------------------------------------------------
// md3_vertex_normal_transform_top
// Vertex yaw/translate and latitude/longitude normal decode pipeline.
// ----------------------------------------------------------------------------
// One vertex is taken in every clock cycle and its result appears on the
// output ports with done high as it leaves the last stage. The four register
// stages are: trig table lookup with the position multiplies, the
// latitude/longitude trig product with position rounding and origin add,
// the yaw multiplies of the normal, and the normal rounding and clamp.
// busy is high only while rst is high. There is no back-pressure: each
// result is shown for one cycle only and must be taken then. Write the
// yaw and origin registers only while no vertex is in flight.
module md3_vertex_normal_transform_top
  import md3vn_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [15:0]           pos_x_in,
  input  logic signed [15:0]           pos_y_in,
  input  logic signed [15:0]           pos_z_in,
  input  logic        [7:0]            normal_lat,
  input  logic        [7:0]            normal_lng,
  input  logic        [31:0]           tex_s_in,
  input  logic        [31:0]           tex_t_in,
  output logic                         done,
  output logic signed [24:0]           pos_x_out,
  output logic signed [24:0]           pos_y_out,
  output logic signed [24:0]           pos_z_out,
  output logic signed [15:0]           norm_x,
  output logic signed [15:0]           norm_y,
  output logic signed [15:0]           norm_z,
  output logic        [31:0]           tex_s_out,
  output logic        [31:0]           tex_t_out,
  input  logic                         cfg_we,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_wdata
);

  logic signed [15:0] yaw_cos;
  logic signed [15:0] yaw_sin;
  logic signed [23:0] origin_x;
  logic signed [23:0] origin_y;
  logic signed [23:0] origin_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_cos  <= 16'sd32767;
      yaw_sin  <= '0;
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_YAW_COS:  yaw_cos  <= cfg_wdata[15:0];
        REG_YAW_SIN:  yaw_sin  <= cfg_wdata[15:0];
        REG_ORIGIN_X: origin_x <= cfg_wdata;
        REG_ORIGIN_Y: origin_y <= cfg_wdata;
        REG_ORIGIN_Z: origin_z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // valid bits
  logic v1, v2, v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // stage 1: table lookup, position products
  logic signed [31:0] s1_xc, s1_ys, s1_xs, s1_yc;
  logic signed [24:0] s1_pz;
  trig_t              s1_cl, s1_sl, s1_sg;
  logic signed [15:0] s1_nz;
  logic        [31:0] s1_ts, s1_tt;

  always_ff @(posedge clk) begin
    s1_xc <= pos_x_in * yaw_cos;
    s1_ys <= pos_y_in * yaw_sin;
    s1_xs <= pos_x_in * yaw_sin;
    s1_yc <= pos_y_in * yaw_cos;
    s1_pz <= 25'(pos_z_in) + 25'(origin_z);
    s1_cl <= rom_cosine(normal_lat);
    s1_sl <= rom_sine(normal_lat);
    s1_sg <= rom_sine(normal_lng);
    s1_nz <= sat16(19'(rom_cosine(normal_lng)));
    s1_ts <= tex_s_in;
    s1_tt <= tex_t_in;
  end

  // stage 2: trig product, position round and translate
  logic signed [32:0] sum_x, sum_y;
  logic signed [17:0] rnd_x, rnd_y;

  always_comb begin
    sum_x = 33'(s1_xc) - 33'(s1_ys) + 33'sd16384;
    sum_y = 33'(s1_xs) + 33'(s1_yc) + 33'sd16384;
    rnd_x = sum_x[32:15];
    rnd_y = sum_y[32:15];
  end

  logic signed [31:0] s2_tx, s2_ty;
  logic signed [24:0] s2_px, s2_py, s2_pz;
  logic signed [15:0] s2_nz;
  logic        [31:0] s2_ts, s2_tt;

  always_ff @(posedge clk) begin
    s2_tx <= s1_cl * s1_sg;
    s2_ty <= s1_sl * s1_sg;
    s2_px <= 25'(rnd_x) + 25'(origin_x);
    s2_py <= 25'(rnd_y) + 25'(origin_y);
    s2_pz <= s1_pz;
    s2_nz <= s1_nz;
    s2_ts <= s1_ts;
    s2_tt <= s1_tt;
  end

  // stage 3: turn the normal by the yaw
  logic signed [47:0] s3_xc, s3_ys, s3_xs, s3_yc;
  logic signed [24:0] s3_px, s3_py, s3_pz;
  logic signed [15:0] s3_nz;
  logic        [31:0] s3_ts, s3_tt;

  always_ff @(posedge clk) begin
    s3_xc <= s2_tx * yaw_cos;
    s3_ys <= s2_ty * yaw_sin;
    s3_xs <= s2_tx * yaw_sin;
    s3_yc <= s2_ty * yaw_cos;
    s3_px <= s2_px;
    s3_py <= s2_py;
    s3_pz <= s2_pz;
    s3_nz <= s2_nz;
    s3_ts <= s2_ts;
    s3_tt <= s2_tt;
  end

  // stage 4: round by 2^30, clamp, drive the outputs
  logic signed [48:0] nsum_x, nsum_y;
  logic signed [18:0] nrnd_x, nrnd_y;

  always_comb begin
    nsum_x = 49'(s3_xc) - 49'(s3_ys) + 49'sd536870912;
    nsum_y = 49'(s3_xs) + 49'(s3_yc) + 49'sd536870912;
    nrnd_x = nsum_x[48:30];
    nrnd_y = nsum_y[48:30];
  end

  always_ff @(posedge clk) begin
    pos_x_out <= s3_px;
    pos_y_out <= s3_py;
    pos_z_out <= s3_pz;
    norm_x    <= sat16(nrnd_x);
    norm_y    <= sat16(nrnd_y);
    norm_z    <= s3_nz;
    tex_s_out <= s3_ts;
    tex_t_out <= s3_tt;
  end

endmodule

FILE: hdl/md3vn_checker.sv
// ----------------------------------------------------------------------------
// md3vn_checker
// Port-level timing checks for the vertex/normal transform, bound to the top.
// ----------------------------------------------------------------------------
module md3vn_checker
  import md3vn_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] tex_s_in,
  input logic [31:0] tex_t_in,
  input logic [31:0] tex_s_out,
  input logic [31:0] tex_t_out
);

  // every accepted beat comes out with done raised
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted beat did not complete after four cycles");

  // no result without a matching accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result strobe without matching input beat");

  // pass-through words stay aligned with their beat
  a_tex_align: assert property (@(posedge clk) disable iff (rst)
    done |-> (tex_s_out == $past(tex_s_in, 4)) && (tex_t_out == $past(tex_t_in, 4)))
    else $error("texture words out of step with their vertex");

  // no hold-off once out of reset
  a_never_busy: assert property (@(posedge clk) !rst |-> !busy)
    else $error("busy raised outside reset");

endmodule

bind md3_vertex_normal_transform_top md3vn_checker u_md3vn_checker (.*);

FILE: sim/tb_md3_vertex_normal_transform_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_md3_vertex_normal_transform_top
// Self-checking bench for the vertex yaw/translate and normal decode pipeline.
// ----------------------------------------------------------------------------
// A driver streams vertex beats from a pending queue with random gaps,
// which one phase turns off. A predictor computes each vertex result
// from its own copy of the yaw and origin registers and its own sine
// table. A monitor compares every done beat with the oldest prediction.
// The run steps through several register settings, the extreme ones
// among them, and drains the pipeline before each rewrite.
module tb_md3_vertex_normal_transform_top;
  import md3vn_pkg::*;

  localparam int PIPE_DEPTH  = 4;
  localparam int DRAIN_LIMIT = 2000;
  localparam int GAP_PCT     = 36;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int TRIG_FRAC   = TRIG_FRAC_BITS;
  localparam int TRIG_SHIFT  = 15 - TRIG_FRAC;

  // round(32768 * sin(k * pi/128)), k = 0..64
  localparam int QUARTER_WAVE [65] = '{
    0,     804,   1608,  2411,  3212,  4011,  4808,  5602,
    6393,  7180,  7962,  8740,  9512,  10279, 11039, 11793,
    12540, 13279, 14010, 14733, 15447, 16151, 16846, 17531,
    18205, 18868, 19520, 20160, 20788, 21403, 22006, 22595,
    23170, 23732, 24279, 24812, 25330, 25833, 26320, 26791,
    27246, 27684, 28106, 28511, 28899, 29269, 29622, 29957,
    30274, 30572, 30853, 31114, 31357, 31581, 31786, 31972,
    32138, 32286, 32413, 32522, 32610, 32679, 32729, 32758,
    32768
  };

  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
    logic [7:0]  lat;
    logic [7:0]  lng;
    logic [31:0] ts;
    logic [31:0] tt;
  } vertex_t;

  typedef struct packed {
    logic [24:0] x;
    logic [24:0] y;
    logic [24:0] z;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic [31:0] ts;
    logic [31:0] tt;
  } vtx_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic signed [15:0]    pos_x_in = '0;
  logic signed [15:0]    pos_y_in = '0;
  logic signed [15:0]    pos_z_in = '0;
  logic [7:0]            normal_lat = '0;
  logic [7:0]            normal_lng = '0;
  logic [31:0]           tex_s_in = '0;
  logic [31:0]           tex_t_in = '0;
  logic                  done;
  logic signed [24:0]    pos_x_out;
  logic signed [24:0]    pos_y_out;
  logic signed [24:0]    pos_z_out;
  logic signed [15:0]    norm_x;
  logic signed [15:0]    norm_y;
  logic signed [15:0]    norm_z;
  logic [31:0]           tex_s_out;
  logic [31:0]           tex_t_out;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow copy of the block's registers
  logic signed [15:0] yaw_c = 16'sd32767;
  logic signed [15:0] yaw_s = 16'sd0;
  logic signed [23:0] org_x = '0;
  logic signed [23:0] org_y = '0;
  logic signed [23:0] org_z = '0;

  vertex_t     pending_q [$];
  vtx_result_t expected_q [$];
  vertex_t     drive_vtx;
  vtx_result_t got_res;
  vtx_result_t want_res;
  int          fail_count = 0;
  int          result_count = 0;
  logic        gaps_off = 1'b0;

  md3_vertex_normal_transform_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .pos_x_in   (pos_x_in),
    .pos_y_in   (pos_y_in),
    .pos_z_in   (pos_z_in),
    .normal_lat (normal_lat),
    .normal_lng (normal_lng),
    .tex_s_in   (tex_s_in),
    .tex_t_in   (tex_t_in),
    .done       (done),
    .pos_x_out  (pos_x_out),
    .pos_y_out  (pos_y_out),
    .pos_z_out  (pos_z_out),
    .norm_x     (norm_x),
    .norm_y     (norm_y),
    .norm_z     (norm_z),
    .tex_s_out  (tex_s_out),
    .tex_t_out  (tex_t_out),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint round_nearest(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp_q15(input longint v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  function automatic longint table_sine(input logic [7:0] code);
    int     r;
    longint m;
    r = int'(code[5:0]);
    m = QUARTER_WAVE[code[6] ? 64 - r : r];
    if (TRIG_SHIFT > 0) begin
      m = ((m + (longint'(1) << (TRIG_SHIFT - 1))) >> TRIG_SHIFT) << TRIG_SHIFT;
    end
    return code[7] ? -m : m;
  endfunction

  function automatic vtx_result_t transform_vertex(input vertex_t v);
    vtx_result_t r;
    longint      yc, ys, px, py, pz, cl, sl, sg, tx, ty;
    yc = yaw_c;
    ys = yaw_s;
    px = $signed(v.px);
    py = $signed(v.py);
    pz = $signed(v.pz);
    r.x  = 25'(round_nearest(px * yc - py * ys, 15) + longint'(org_x));
    r.y  = 25'(round_nearest(px * ys + py * yc, 15) + longint'(org_y));
    r.z  = 25'(pz + longint'(org_z));
    cl = table_sine(8'(v.lat + 8'd64));
    sl = table_sine(v.lat);
    sg = table_sine(v.lng);
    tx = cl * sg;
    ty = sl * sg;
    r.nx = 16'(clamp_q15(round_nearest(tx * yc - ty * ys, 30)));
    r.ny = 16'(clamp_q15(round_nearest(tx * ys + ty * yc, 30)));
    r.nz = 16'(clamp_q15(table_sine(8'(v.lng + 8'd64))));
    r.ts = v.ts;
    r.tt = v.tt;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present the head of the pending queue, hold while busy
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_q.push_back(transform_vertex(drive_vtx));
      end
      if (!start || !busy) begin
        if (pending_q.size() > 0 && (gaps_off || $urandom_range(99) >= GAP_PCT)) begin
          drive_vtx = pending_q.pop_front();
          start      <= 1'b1;
          pos_x_in   <= drive_vtx.px;
          pos_y_in   <= drive_vtx.py;
          pos_z_in   <= drive_vtx.pz;
          normal_lat <= drive_vtx.lat;
          normal_lng <= drive_vtx.lng;
          tex_s_in   <= drive_vtx.ts;
          tex_t_in   <= drive_vtx.tt;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every done beat against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done) begin
      got_res = '{x: pos_x_out, y: pos_y_out, z: pos_z_out, nx: norm_x, ny: norm_y,
                  nz: norm_z, ts: tex_s_out, tt: tex_t_out};
      if (expected_q.size() == 0) begin
        if (fail_count < 10) begin
          $display("unexpected result beat at %0t", $realtime);
        end
        fail_count++;
      end else begin
        want_res = expected_q.pop_front();
        if (got_res.x !== want_res.x || got_res.y !== want_res.y ||
            got_res.z !== want_res.z || got_res.nx !== want_res.nx ||
            got_res.ny !== want_res.ny || got_res.nz !== want_res.nz ||
            got_res.ts !== want_res.ts || got_res.tt !== want_res.tt) begin
          if (fail_count < 10) begin
            $display("beat %0d exp pos %0d %0d %0d nrm %0d %0d %0d tex %h %h",
                     result_count, $signed(want_res.x), $signed(want_res.y),
                     $signed(want_res.z), $signed(want_res.nx), $signed(want_res.ny),
                     $signed(want_res.nz), want_res.ts, want_res.tt);
            $display("beat %0d got pos %0d %0d %0d nrm %0d %0d %0d tex %h %h",
                     result_count, $signed(got_res.x), $signed(got_res.y),
                     $signed(got_res.z), $signed(got_res.nx), $signed(got_res.ny),
                     $signed(got_res.nz), got_res.ts, got_res.tt);
          end
          fail_count++;
        end
      end
      result_count++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_YAW_COS:  yaw_c = data[15:0];
      REG_YAW_SIN:  yaw_s = data[15:0];
      REG_ORIGIN_X: org_x = data;
      REG_ORIGIN_Y: org_y = data;
      REG_ORIGIN_Z: org_z = data;
      default: ;
    endcase
  endtask

  // wait until every beat is out, then let the pipeline settle
  task automatic wait_drained();
    int cnt;
    cnt = 0;
    @(negedge clk);
    while ((pending_q.size() > 0 || start || expected_q.size() > 0) && cnt < DRAIN_LIMIT) begin
      @(negedge clk);
      cnt++;
    end
    if (expected_q.size() > 0) begin
      $display("%0d vertex results never arrived", expected_q.size());
      fail_count += expected_q.size();
      expected_q.delete();
    end
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  task automatic add_vertex(input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] pz, input logic [7:0] lat,
                            input logic [7:0] lng, input logic [31:0] ts,
                            input logic [31:0] tt);
    pending_q.push_back('{px: px, py: py, pz: pz, lat: lat, lng: lng, ts: ts, tt: tt});
  endtask

  function automatic logic [15:0] rand_pos();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly uniform, some quadrant edges
  function automatic logic [7:0] rand_angle();
    if ($urandom_range(4) == 0) begin
      return 8'($urandom_range(3) * 64 + ($urandom_range(1) ? 0 : 63));
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic set_phase_regs(input int p);
    logic [15:0] yc, ys;
    logic [23:0] ox, oy, oz;
    real         ang;
    ang = $urandom_range(1023) * 6.283185307179586 / 1024.0;
    yc  = 16'(int'(32767.0 * $cos(ang)));
    ys  = 16'(int'(32767.0 * $sin(ang)));
    ox  = 24'($urandom);
    oy  = 24'($urandom);
    oz  = 24'($urandom);
    case (p)
      0: begin
        yc = 16'h8000; ys = 16'h8000;
        ox = 24'h7fffff; oy = 24'h800000; oz = 24'h7fffff;
      end
      1: begin
        yc = 16'h7fff; ys = 16'h7fff;
        ox = 24'h800000; oy = 24'h7fffff; oz = 24'h800000;
      end
      2: begin
        yc = 16'h0000; ys = 16'h8000;
        ox = '0; oy = '0; oz = '0;
      end
      default: begin
        if ($urandom_range(1)) begin
          yc = 16'($urandom);
          ys = 16'($urandom);
        end
      end
    endcase
    // bits above the yaw width carry noise and must be dropped
    write_reg(REG_YAW_COS, {8'($urandom), yc});
    write_reg(REG_YAW_SIN, {8'($urandom), ys});
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    // index past the last register: no effect
    write_reg(3'(REG_ORIGIN_Z) + 3'($urandom_range(1, 3)), 24'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] edge_pos [5];
    logic [7:0]  lat_set  [5];
    logic [7:0]  lng_set  [4];
    int          k;
    edge_pos = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff};
    lat_set  = '{8'd0, 8'd64, 8'd128, 8'd192, 8'd255};
    lng_set  = '{8'd0, 8'd64, 8'd128, 8'd192};
    k = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: unit yaw, table hits on the exact +1 and -1 entries
    for (int li = 0; li < 5; li++) begin
      for (int gi = 0; gi < 4; gi++) begin
        add_vertex(edge_pos[k % 5], edge_pos[(k + 1) % 5], edge_pos[(k + 3) % 5],
                   lat_set[li], lng_set[gi], (k % 2) ? 32'hffffffff : 32'h0,
                   (k % 2) ? 32'h0 : 32'hffffffff);
        k++;
      end
    end
    wait_drained();

    // half-scale yaw puts positions on exact rounding ties
    write_reg(REG_YAW_COS, 24'h004000);
    write_reg(REG_YAW_SIN, 24'h00c000);
    @(negedge clk);
    add_vertex(16'd1, 16'd0, 16'd5, 8'd16, 8'd48, 32'h1234_5678, 32'h9abc_def0);
    add_vertex(16'hffff, 16'd0, 16'd0, 8'd80, 8'd200, 32'h0, 32'h0);
    add_vertex(16'd1, 16'd2, 16'hffff, 8'd1, 8'd1, 32'ha5a5_a5a5, 32'h5a5a_5a5a);
    add_vertex(16'hffff, 16'hfffe, 16'h8000, 8'd254, 8'd254, 32'h0, 32'hffffffff);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      set_phase_regs(p);
      gaps_off = (p == 3);
      @(negedge clk);
      repeat (PHASE_ITEMS) begin
        pending_q.push_back('{px: rand_pos(), py: rand_pos(), pz: rand_pos(),
                              lat: rand_angle(), lng: rand_angle(),
                              ts: 32'($urandom), tt: 32'($urandom)});
      end
      wait_drained();
    end

    repeat (PIPE_DEPTH * 2) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/md3vn_pkg.sv
hdl/md3_vertex_normal_transform_top.sv
hdl/md3vn_checker.sv
sim/tb_md3_vertex_normal_transform_top.sv
